// File: src/lav_pkg.sv
// ----------------------------------------------------------------------------
// lav_pkg
// Shared widths and latency figures for the look-at view matrix pipeline.
// ----------------------------------------------------------------------------
package lav_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W       = 32;
  localparam int NORM_W        = 31;
  localparam int RAD_W         = 64;
  localparam int ROOT_W        = 32;
  localparam int NORM_FRONT    = 5;

  function automatic int div_latency(input int frac);
    return frac + 3;
  endfunction

  function automatic int norm_latency(input int frac);
    return NORM_FRONT + ROOT_W + div_latency(frac) + 1;
  endfunction

endpackage

// File: src/look_at_view_matrix.sv
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Look-at view rotation: rows side, true up and back from eye, target, up.
//
// Takes one request per cycle and returns one result per request, in order.
// Each request passes through the two normalizers in series, each a 32-stage
// square root followed by a (FRAC_BITS + 3)-stage divider. A two-entry output
// buffer keeps requests flowing while a result waits; the input stalls only
// once both are full.
// ----------------------------------------------------------------------------
module look_at_view_matrix #(
  parameter int FRAC_BITS = lav_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // eye_x, eye_y, eye_z, target_x, target_y, target_z,
  // upward_x, upward_y, upward_z (32 bits each)
  input  logic [9*lav_pkg::COORD_W-1:0] s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // side_x, side_y, side_z, true_up_x, true_up_y, true_up_z,
  // back_x, back_y, back_z (FRAC_BITS+2 bits each), zero pad
  output logic [((9*(FRAC_BITS+2)+7)/8)*8-1:0] m_axis_tdata,
  // degenerate
  output logic                         m_axis_tuser
);
  import lav_pkg::*;

  localparam int OW    = FRAC_BITS + 2;
  localparam int CW    = FRAC_BITS + 35;
  localparam int PW    = OW + COORD_W;
  localparam int SW    = 2 * OW;
  localparam int TW    = SW + 1;
  localparam int RW    = TW + 1 - FRAC_BITS;
  localparam int RES_W = 9 * OW;
  localparam int ODW   = ((9 * OW + 7) / 8) * 8;
  localparam int LN    = norm_latency(FRAC_BITS);
  localparam int LAT   = 2 * LN + 7;
  localparam logic [RW-1:0] UNIT_R = RW'(1) << FRAC_BITS;
  localparam logic [TW:0]   HALF   = (TW+1)'(1) << (FRAC_BITS - 1);

  logic advance;
  logic [LAT-1:0] vld;

  logic signed [COORD_W-1:0] d1  [3];
  logic [3*COORD_W-1:0]      up1;
  logic [3*COORD_W-1:0]      up_d;
  logic signed [COORD_W-1:0] up_a [3];
  logic signed [COORD_W:0]   diff [3];

  logic signed [OW-1:0] f_n [3];
  logic                 zf_n;

  logic signed [PW-1:0] p2 [6];
  logic signed [CW-1:0] c3 [3];
  logic [3*OW:0]        f2, f3, f_sd;

  logic signed [OW-1:0] s_n [3];
  logic                 zs_n;
  logic signed [OW-1:0] f_s [3];

  logic signed [SW-1:0] p4 [6];
  logic signed [TW-1:0] t5 [3];
  logic [2:0]           neg6;
  logic [RW-1:0]        r6 [3];
  logic [TW-1:0]        mag [3];
  logic [TW:0]          rsum [3];
  logic [6*OW:0]        sf_d;
  logic signed [OW-1:0] s7 [3];
  logic signed [OW-1:0] f7 [3];
  logic                 ok7;
  logic [RW-1:0]        rc [3];
  logic signed [OW-1:0] uu [3];

  logic [RES_W-1:0] res;
  logic             res_deg;
  logic [RES_W-1:0] out_data, skid_data;
  logic             out_deg, skid_deg;
  logic             out_vld, skid_vld;

  assign advance       = !skid_vld;
  assign s_axis_tready = advance && !rst;

  // input differences with saturation, up held alongside
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = $signed({s_axis_tdata[COORD_W*(3+i)+COORD_W-1], s_axis_tdata[COORD_W*(3+i) +: COORD_W]})
              - $signed({s_axis_tdata[COORD_W*i+COORD_W-1], s_axis_tdata[COORD_W*i +: COORD_W]});
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        if (diff[i][COORD_W] != diff[i][COORD_W-1]) begin
          d1[i] <= diff[i][COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end else begin
          d1[i] <= diff[i][COORD_W-1:0];
        end
      end
      up1 <= s_axis_tdata[9*COORD_W-1:6*COORD_W];
    end
  end

  lav_norm #(.W(COORD_W), .FRAC(FRAC_BITS)) u_norm_fwd (
    .clk  (clk),
    .en   (advance),
    .v    (d1),
    .u    (f_n),
    .zero (zf_n)
  );

  lav_delay #(.W(3*COORD_W), .D(LN)) u_up_dly (
    .clk  (clk),
    .en   (advance),
    .din  (up1),
    .dout (up_d)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      up_a[i] = up_d[i*COORD_W +: COORD_W];
    end
  end

  // cross product of forward and up
  always_ff @(posedge clk) begin
    if (advance) begin
      p2[0] <= f_n[1] * up_a[2];
      p2[1] <= f_n[2] * up_a[1];
      p2[2] <= f_n[2] * up_a[0];
      p2[3] <= f_n[0] * up_a[2];
      p2[4] <= f_n[0] * up_a[1];
      p2[5] <= f_n[1] * up_a[0];
      f2    <= {zf_n, f_n[2], f_n[1], f_n[0]};
      for (int i = 0; i < 3; i++) begin
        c3[i] <= CW'(p2[2*i]) - CW'(p2[2*i+1]);
      end
      f3 <= f2;
    end
  end

  lav_norm #(.W(CW), .FRAC(FRAC_BITS)) u_norm_side (
    .clk  (clk),
    .en   (advance),
    .v    (c3),
    .u    (s_n),
    .zero (zs_n)
  );

  lav_delay #(.W(3*OW+1), .D(LN)) u_fwd_dly (
    .clk  (clk),
    .en   (advance),
    .din  (f3),
    .dout (f_sd)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      f_s[i] = f_sd[i*OW +: OW];
    end
  end

  lav_delay #(.W(6*OW+1), .D(3)) u_row_dly (
    .clk  (clk),
    .en   (advance),
    .din  ({!(f_sd[3*OW] || zs_n), f_s[2], f_s[1], f_s[0], s_n[2], s_n[1], s_n[0]}),
    .dout (sf_d)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s7[i]   = sf_d[i*OW +: OW];
      f7[i]   = sf_d[(3+i)*OW +: OW];
      mag[i]  = t5[i][TW-1] ? $unsigned(-t5[i]) : $unsigned(t5[i]);
      rsum[i] = (TW+1)'(mag[i]) + HALF;
      rc[i]   = (r6[i] > UNIT_R) ? UNIT_R : r6[i];
      uu[i]   = neg6[i] ? -$signed(OW'(rc[i])) : $signed(OW'(rc[i]));
    end
    ok7 = sf_d[6*OW];
  end

  // true up = side x forward, rounded back to the output format
  always_ff @(posedge clk) begin
    if (advance) begin
      p4[0] <= s_n[1] * f_s[2];
      p4[1] <= s_n[2] * f_s[1];
      p4[2] <= s_n[2] * f_s[0];
      p4[3] <= s_n[0] * f_s[2];
      p4[4] <= s_n[0] * f_s[1];
      p4[5] <= s_n[1] * f_s[0];
      for (int i = 0; i < 3; i++) begin
        t5[i]   <= TW'(p4[2*i]) - TW'(p4[2*i+1]);
        neg6[i] <= t5[i][TW-1];
        r6[i]   <= rsum[i][TW:FRAC_BITS];
      end
      res_deg <= !ok7;
      if (ok7) begin
        res <= {-f7[2], -f7[1], -f7[0], uu[2], uu[1], uu[0], s7[2], s7[1], s7[0]};
      end else begin
        res <= '0;
      end
    end
  end

  // valid chain and output buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      out_vld  <= 1'b0;
      skid_vld <= 1'b0;
    end else begin
      if (advance) begin
        vld <= {vld[LAT-2:0], s_axis_tvalid};
      end
      if (skid_vld) begin
        if (m_axis_tready) begin
          skid_vld <= 1'b0;
        end
      end else if (vld[LAT-1]) begin
        if (out_vld && !m_axis_tready) begin
          skid_vld <= 1'b1;
        end else begin
          out_vld <= 1'b1;
        end
      end else if (m_axis_tready) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld) begin
      if (m_axis_tready) begin
        out_data <= skid_data;
        out_deg  <= skid_deg;
      end
    end else if (vld[LAT-1]) begin
      if (out_vld && !m_axis_tready) begin
        skid_data <= res;
        skid_deg  <= res_deg;
      end else begin
        out_data <= res;
        out_deg  <= res_deg;
      end
    end
  end

  assign m_axis_tvalid = out_vld;
  assign m_axis_tdata  = ODW'(out_data);
  assign m_axis_tuser  = out_deg;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_vld |-> out_vld)
    else $error("skid entry held without an output entry");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (rst)
    (vld[LAT-1] && !skid_vld && out_vld && !m_axis_tready) |=> skid_vld)
    else $error("finished request dropped on output stall");

  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    (out_vld && out_deg) |-> (out_data == '0))
    else $error("degenerate result carries nonzero rows");

endmodule

// File: src/lav_isqrt.sv
// ----------------------------------------------------------------------------
// lav_isqrt
// Pipelined integer square root, one result bit per stage, with side payload.
// ----------------------------------------------------------------------------
module lav_isqrt #(
  parameter int PW = 1
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [lav_pkg::RAD_W-1:0]    rad,
  input  logic [PW-1:0]                pay_in,
  output logic [lav_pkg::ROOT_W-1:0]   root,
  output logic [PW-1:0]                pay_out
);
  import lav_pkg::*;

  localparam int N     = ROOT_W;
  localparam int REM_W = ROOT_W + 3;

  logic [RAD_W-1:0]  src_q [N];
  logic [REM_W-1:0]  rem_q [N];
  logic [ROOT_W-1:0] rt_q  [N];
  logic [PW-1:0]     pay_q [N];

  logic [RAD_W-1:0]  s_in  [N];
  logic [REM_W-1:0]  r_in  [N];
  logic [ROOT_W-1:0] t_in  [N];
  logic [REM_W-1:0]  acc   [N];
  logic [REM_W-1:0]  trial [N];
  logic [N-1:0]      fit;

  always_comb begin
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        s_in[k] = rad;
        r_in[k] = '0;
        t_in[k] = '0;
      end else begin
        s_in[k] = src_q[k-1];
        r_in[k] = rem_q[k-1];
        t_in[k] = rt_q[k-1];
      end
      acc[k]   = {r_in[k][REM_W-3:0], s_in[k][RAD_W-1 -: 2]};
      trial[k] = {1'b0, t_in[k], 2'b01};
      fit[k]   = acc[k] >= trial[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pay_q[0] <= pay_in;
      for (int k = 1; k < N; k++) begin
        pay_q[k] <= pay_q[k-1];
      end
      for (int k = 0; k < N; k++) begin
        src_q[k] <= {s_in[k][RAD_W-3:0], 2'b00};
        rem_q[k] <= fit[k] ? acc[k] - trial[k] : acc[k];
        rt_q[k]  <= {t_in[k][ROOT_W-2:0], fit[k]};
      end
    end
  end

  assign root    = rt_q[N-1];
  assign pay_out = pay_q[N-1];

endmodule

// File: src/lav_div.sv
// ----------------------------------------------------------------------------
// lav_div
// Pipelined restoring divider: round(num * 2^FRAC / den), one quotient bit
// per stage, for num not above den.
// ----------------------------------------------------------------------------
module lav_div #(
  parameter int FRAC = lav_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [lav_pkg::NORM_W-1:0]  num,
  input  logic [lav_pkg::ROOT_W-1:0]  den,
  output logic [FRAC+1:0]             quo
);
  import lav_pkg::*;

  localparam int QB    = FRAC + 2;
  localparam int NUM_W = NORM_W + FRAC + 1;

  logic [NUM_W-1:0]  n_q;
  logic [ROOT_W-1:0] den0_q;

  logic [ROOT_W-1:0] rem_q [QB];
  logic [ROOT_W-1:0] den_q [QB];
  logic [QB-1:0]     low_q [QB];
  logic [QB-1:0]     q_q   [QB];

  logic [ROOT_W-1:0] r_in [QB];
  logic [ROOT_W-1:0] d_in [QB];
  logic [QB-1:0]     l_in [QB];
  logic [QB-1:0]     qi   [QB];
  logic [ROOT_W:0]   acc  [QB];
  logic [QB-1:0]     fit;

  always_comb begin
    for (int k = 0; k < QB; k++) begin
      if (k == 0) begin
        r_in[k] = ROOT_W'(n_q[NUM_W-1:QB]);
        d_in[k] = den0_q;
        l_in[k] = n_q[QB-1:0];
        qi[k]   = '0;
      end else begin
        r_in[k] = rem_q[k-1];
        d_in[k] = den_q[k-1];
        l_in[k] = low_q[k-1];
        qi[k]   = q_q[k-1];
      end
      acc[k] = {r_in[k], l_in[k][QB-1]};
      fit[k] = acc[k] >= {1'b0, d_in[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_q    <= (NUM_W'(num) << FRAC) + NUM_W'(den >> 1);
      den0_q <= den;
      for (int k = 0; k < QB; k++) begin
        rem_q[k] <= fit[k] ? ROOT_W'(acc[k] - {1'b0, d_in[k]}) : ROOT_W'(acc[k]);
        den_q[k] <= d_in[k];
        low_q[k] <= {l_in[k][QB-2:0], 1'b0};
        q_q[k]   <= {qi[k][QB-2:0], fit[k]};
      end
    end
  end

  assign quo = q_q[QB-1];

endmodule

// File: src/lav_delay.sv
// ----------------------------------------------------------------------------
// lav_delay
// Enabled register chain that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
module lav_delay #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] pipe [D];

  always_ff @(posedge clk) begin
    if (en) begin
      pipe[0] <= din;
      for (int k = 1; k < D; k++) begin
        pipe[k] <= pipe[k-1];
      end
    end
  end

  assign dout = pipe[D-1];

endmodule

// File: src/lav_norm.sv
// ----------------------------------------------------------------------------
// lav_norm
// Pipelined vector normalizer: scale to a common exponent, sum of squares,
// square root, three dividers, clamp and sign.
// ----------------------------------------------------------------------------
module lav_norm #(
  parameter int W    = 32,
  parameter int FRAC = lav_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [W-1:0]  v [3],
  output logic signed [FRAC+1:0] u [3],
  output logic                 zero
);
  import lav_pkg::*;

  localparam int OW    = FRAC + 2;
  localparam int BL_W  = $clog2(W + 1);
  localparam int PAY_W = 3 * NORM_W + 4;
  localparam logic [OW-1:0] UNIT = OW'(1) << FRAC;

  logic [W-1:0]      mag1 [3];
  logic [2:0]        neg1;
  logic [W-1:0]      orv1;

  logic [W-1:0]      mag2 [3];
  logic [2:0]        neg2;
  logic              zero2;
  logic [BL_W-1:0]   bl2;
  logic [BL_W-1:0]   bl_next;

  logic [NORM_W-1:0] nm3 [3];
  logic [2:0]        neg3;
  logic              zero3;
  logic [W+NORM_W-1:0] wide [3];

  logic [2*NORM_W-1:0] sq4 [3];
  logic [NORM_W-1:0] nm4 [3];
  logic [2:0]        neg4;
  logic              zero4;

  logic [RAD_W-1:0]  sum5;
  logic [NORM_W-1:0] nm5 [3];
  logic [2:0]        neg5;
  logic              zero5;

  logic [ROOT_W-1:0] root;
  logic [PAY_W-1:0]  pay_out;
  logic [NORM_W-1:0] nm_r [3];
  logic [3:0]        flag_d;
  logic [OW-1:0]     quo [3];
  logic [OW-1:0]     qc  [3];

  always_comb begin
    bl_next = '0;
    for (int b = 0; b < W; b++) begin
      if (orv1[b]) begin
        bl_next = BL_W'(b + 1);
      end
    end
    for (int i = 0; i < 3; i++) begin
      wide[i] = {mag2[i], {NORM_W{1'b0}}} >> bl2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag1[i] <= v[i][W-1] ? $unsigned(-v[i]) : $unsigned(v[i]);
        neg1[i] <= v[i][W-1];
      end
      orv1 <= (v[0][W-1] ? $unsigned(-v[0]) : $unsigned(v[0]))
            | (v[1][W-1] ? $unsigned(-v[1]) : $unsigned(v[1]))
            | (v[2][W-1] ? $unsigned(-v[2]) : $unsigned(v[2]));

      mag2  <= mag1;
      neg2  <= neg1;
      zero2 <= (orv1 == '0);
      bl2   <= bl_next;

      for (int i = 0; i < 3; i++) begin
        nm3[i] <= wide[i][NORM_W-1:0];
      end
      neg3  <= neg2;
      zero3 <= zero2;

      for (int i = 0; i < 3; i++) begin
        sq4[i] <= nm3[i] * nm3[i];
      end
      nm4   <= nm3;
      neg4  <= neg3;
      zero4 <= zero3;

      sum5  <= RAD_W'(sq4[0]) + RAD_W'(sq4[1]) + RAD_W'(sq4[2]);
      nm5   <= nm4;
      neg5  <= neg4;
      zero5 <= zero4;
    end
  end

  lav_isqrt #(.PW(PAY_W)) u_isqrt (
    .clk     (clk),
    .en      (en),
    .rad     (sum5),
    .pay_in  ({zero5, neg5, nm5[2], nm5[1], nm5[0]}),
    .root    (root),
    .pay_out (pay_out)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nm_r[i] = pay_out[i*NORM_W +: NORM_W];
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_div
    lav_div #(.FRAC(FRAC)) u_div (
      .clk (clk),
      .en  (en),
      .num (nm_r[i]),
      .den (root),
      .quo (quo[i])
    );
  end

  lav_delay #(.W(4), .D(div_latency(FRAC))) u_flag_dly (
    .clk  (clk),
    .en   (en),
    .din  (pay_out[PAY_W-1 -: 4]),
    .dout (flag_d)
  );

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc[i] = (quo[i] > UNIT) ? UNIT : quo[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero <= flag_d[3];
      for (int i = 0; i < 3; i++) begin
        if (flag_d[3]) begin
          u[i] <= '0;
        end else begin
          u[i] <= flag_d[i] ? -$signed(qc[i]) : $signed(qc[i]);
        end
      end
    end
  end

endmodule
